[rtl/dffir_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dffir_pkg;

    localparam int MAX_TAPS       = 8;
    localparam int SAMPLE_BITS    = 10;
    localparam int COEF_FRAC_BITS = 14;

    localparam int COEF_W     = 16;
    localparam int ORDER_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int OUT_W      = 32;
    localparam int COEF_SET_W = 2 * CFG_DATA_W;

    localparam int POS_W     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int OPND_W    = OUT_W + 1;
    localparam int PROD_W    = OPND_W + COEF_W;
    localparam int ACC_W     = PROD_W + POS_W + 2;
    localparam int S_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] CFG_ORDER   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_FEED_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_FEED_HI = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_BACK_LO = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_BACK_HI = CFG_IDX_W'(5);

    typedef struct packed {
        logic             rd_en;
        logic [POS_W-1:0] rd_addr;
        logic             smp_we;
        logic             out_we;
        logic [POS_W-1:0] wr_addr;
    } t_mem_req;

    typedef struct packed {
        logic             clear;
        logic             vld;
        logic             fb;
        logic [POS_W-1:0] tap;
    } t_mac_cmd;

    function automatic logic [POS_W:0] eff_order(input logic [ORDER_W-1:0] ord);
        logic [POS_W:0] k;
        if (ord == '0) begin
            k = (POS_W+1)'(1);
        end else if (ord > ORDER_W'(MAX_TAPS)) begin
            k = (POS_W+1)'(MAX_TAPS);
        end else begin
            k = (POS_W+1)'(ord);
        end
        return k;
    endfunction

endpackage

`default_nettype wire

[rtl/direct_form_fir_iir_filter.sv]
// an accepted sample gives its result on o_m_axis_tvalid once all k taps are
// done, k being the order in use (1 to 8); one shared multiplier takes a
// feedforward and a feedback product per tap, one read of the history per tap
// a new sample is taken only after the last result is loaded into the output
// register, later while a finished result waits on a full output register
// reset: synchronous, active low; histories read as zero, order 1, fir mode,
// all coefficients zero, write position zero
`timescale 1ns / 1ps
`default_nettype none

module direct_form_fir_iir_filter (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // [9:0] sample, rest zero
    input  wire logic [dffir_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // [31:0] filtered
    output logic      [dffir_pkg::M_TDATA_W-1:0]     o_m_axis_tdata,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [dffir_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [dffir_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import dffir_pkg::*;

    logic [ORDER_W-1:0]    r_order;
    logic                  r_mode;
    logic [CFG_DATA_W-1:0] r_feed_lo;
    logic [CFG_DATA_W-1:0] r_feed_hi;
    logic [CFG_DATA_W-1:0] r_back_lo;
    logic [CFG_DATA_W-1:0] r_back_hi;
    logic                  r_out_vld;
    logic [OUT_W-1:0]      r_out_data;

    t_mem_req               w_mem;
    t_mac_cmd               w_mac;
    logic                   w_fin;
    logic                   w_mac_busy;
    logic                   w_out_free;
    logic                   w_in_acc;
    logic [SAMPLE_BITS-1:0] w_smp_q;
    logic [OUT_W-1:0]       w_out_q;
    logic [OUT_W-1:0]       w_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order   <= ORDER_W'(1);
            r_mode    <= 1'b0;
            r_feed_lo <= '0;
            r_feed_hi <= '0;
            r_back_lo <= '0;
            r_back_hi <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ORDER:   r_order   <= i_cfg_data[ORDER_W-1:0];
                CFG_MODE:    r_mode    <= i_cfg_data[0];
                CFG_FEED_LO: r_feed_lo <= i_cfg_data;
                CFG_FEED_HI: r_feed_hi <= i_cfg_data;
                CFG_BACK_LO: r_back_lo <= i_cfg_data;
                CFG_BACK_HI: r_back_hi <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_in_acc   = i_s_axis_tvalid & o_s_axis_tready;
    assign w_out_free = !r_out_vld || i_m_axis_tready;

    dffir_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_order    (r_order),
        .i_mac_busy (w_mac_busy),
        .i_out_free (w_out_free),
        .o_ready    (o_s_axis_tready),
        .o_mem      (w_mem),
        .o_mac      (w_mac),
        .o_fin      (w_fin)
    );

    dffir_hist u_hist (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_mem),
        .i_smp_wdata (i_s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_out_wdata (w_result),
        .o_smp_q     (w_smp_q),
        .o_out_q     (w_out_q)
    );

    dffir_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_mac),
        .i_smp_q     (w_smp_q),
        .i_out_q     (w_out_q),
        .i_feed      ({r_feed_hi, r_feed_lo}),
        .i_back      ({r_back_hi, r_back_lo}),
        .i_recursive (r_mode),
        .o_busy      (w_mac_busy),
        .o_result    (w_result)
    );

    // output register lets the next transaction in while a result waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_fin) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin) begin
            r_out_data <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = M_TDATA_W'(r_out_data);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_s_axis_tready)
        else $error("input taken again right after a transaction");

    a_fin_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin |-> !w_mac_busy && w_out_free)
        else $error("result loaded while the mac pipeline is busy or output full");

    a_idle_mac_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !w_mac_busy && !w_mac.vld)
        else $error("mac active while waiting for input");

    a_no_overlap_rw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem.rd_en |-> !w_mem.smp_we && !w_mem.out_we)
        else $error("history read and write in the same cycle");

endmodule

`default_nettype wire

[rtl/dffir_hist.sv]
`timescale 1ns / 1ps
`default_nettype none

module dffir_hist (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire dffir_pkg::t_mem_req              i_req,
    input  wire logic [dffir_pkg::SAMPLE_BITS-1:0] i_smp_wdata,
    input  wire logic [dffir_pkg::OUT_W-1:0]      i_out_wdata,
    output logic      [dffir_pkg::SAMPLE_BITS-1:0] o_smp_q,
    output logic      [dffir_pkg::OUT_W-1:0]      o_out_q
);
    import dffir_pkg::*;

    logic [SAMPLE_BITS-1:0] r_smp_mem [MAX_TAPS];
    logic [OUT_W-1:0]       r_out_mem [MAX_TAPS];
    logic [MAX_TAPS-1:0]    r_vld;
    logic [SAMPLE_BITS-1:0] r_smp_rd;
    logic [OUT_W-1:0]       r_out_rd;
    logic                   r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.smp_we) begin
            r_smp_mem[i_req.wr_addr] <= i_smp_wdata;
        end
        if (i_req.out_we) begin
            r_out_mem[i_req.wr_addr] <= i_out_wdata;
        end
        if (i_req.rd_en) begin
            r_smp_rd <= r_smp_mem[i_req.rd_addr];
            r_out_rd <= r_out_mem[i_req.rd_addr];
        end
    end

    // both stores share a valid bit: an entry becomes valid with its sample,
    // and its output slot is written only once the item has finished
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.smp_we) begin
                r_vld[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_vld[i_req.rd_addr];
            end
        end
    end

    assign o_smp_q = r_rd_vld ? r_smp_rd : '0;
    assign o_out_q = r_rd_vld ? r_out_rd : '0;

endmodule

`default_nettype wire

[rtl/dffir_mac.sv]
`timescale 1ns / 1ps
`default_nettype none

module dffir_mac (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire dffir_pkg::t_mac_cmd               i_cmd,
    input  wire logic [dffir_pkg::SAMPLE_BITS-1:0] i_smp_q,
    input  wire logic [dffir_pkg::OUT_W-1:0]       i_out_q,
    input  wire logic [dffir_pkg::COEF_SET_W-1:0]  i_feed,
    input  wire logic [dffir_pkg::COEF_SET_W-1:0]  i_back,
    input  wire logic                              i_recursive,
    output logic                                   o_busy,
    output logic      [dffir_pkg::OUT_W-1:0]       o_result
);
    import dffir_pkg::*;

    t_mac_cmd                  r_m;
    logic [OUT_W-1:0]          r_y_hold;
    logic                      r_p_vld;
    logic                      r_p_fb;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;

    logic signed [OPND_W-1:0]  w_opnd;
    logic signed [COEF_W-1:0]  w_coef;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [ACC_W-1:0]   w_term;
    logic [ACC_W-OUT_W:0]      w_top;

    // the sample and the past output of one tap come from one read; the
    // output is held for the feedback product in the following cycle
    always_comb begin
        if (r_m.fb) begin
            w_opnd = $signed({r_y_hold[OUT_W-1], r_y_hold});
            if (i_recursive && (r_m.tap != '0)) begin
                w_coef = $signed(i_back[r_m.tap*COEF_W +: COEF_W]);
            end else begin
                w_coef = '0;
            end
        end else begin
            w_opnd = $signed({{(OPND_W-SAMPLE_BITS){1'b0}}, i_smp_q});
            w_coef = $signed(i_feed[r_m.tap*COEF_W +: COEF_W]);
        end
    end

    assign w_prod = w_opnd * w_coef;

    // feedback products drop the fraction with floor
    assign w_term = r_p_fb ? -(ACC_W'(r_prod >>> COEF_FRAC_BITS)) : ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (r_m.vld && !r_m.fb) begin
            r_y_hold <= i_out_q;
        end
        r_prod <= w_prod;
        r_p_fb <= r_m.fb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m     <= '0;
            r_p_vld <= 1'b0;
            r_acc   <= '0;
        end else begin
            r_m     <= i_cmd;
            r_p_vld <= r_m.vld;
            if (i_cmd.clear) begin
                r_acc <= '0;
            end else if (r_p_vld) begin
                r_acc <= r_acc + w_term;
            end
        end
    end

    assign o_busy = r_m.vld | r_p_vld;

    assign w_top = r_acc[ACC_W-1:OUT_W-1];

    always_comb begin
        if ((&w_top) || !(|w_top)) begin
            o_result = r_acc[OUT_W-1:0];
        end else if (r_acc[ACC_W-1]) begin
            o_result = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            o_result = {1'b0, {(OUT_W-1){1'b1}}};
        end
    end

endmodule

`default_nettype wire

[rtl/dffir_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module dffir_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic [dffir_pkg::ORDER_W-1:0] i_order,
    input  wire logic                          i_mac_busy,
    input  wire logic                          i_out_free,
    output logic                               o_ready,
    output dffir_pkg::t_mem_req                o_mem,
    output dffir_pkg::t_mac_cmd                o_mac,
    output logic                               o_fin
);
    import dffir_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W:0]   r_step, n_step;
    logic [POS_W:0]   r_k, n_k;

    logic [POS_W:0]   w_k_new;
    logic [POS_W:0]   w_pos_inc;
    logic [POS_W-1:0] w_pos_new;
    logic [POS_W-1:0] w_tap;
    logic [POS_W:0]   w_wrap;
    logic [POS_W-1:0] w_j;
    logic [POS_W:0]   w_last_step;

    assign w_k_new   = eff_order(i_order);
    assign w_pos_inc = {1'b0, r_pos} + (POS_W+1)'(1);
    assign w_pos_new = (w_pos_inc >= w_k_new) ? '0 : w_pos_inc[POS_W-1:0];

    // tap i reads history entry (pos - i) mod k
    assign w_tap       = r_step[POS_W:1];
    assign w_wrap      = {1'b0, r_pos} + r_k - {1'b0, w_tap};
    assign w_j         = (r_pos >= w_tap) ? (r_pos - w_tap) : w_wrap[POS_W-1:0];
    assign w_last_step = {r_k[POS_W-1:0], 1'b0} - (POS_W+1)'(1);

    assign o_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_step  = r_step;
        n_k     = r_k;
        o_mem   = '0;
        o_mac   = '0;
        o_fin   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_pos         = w_pos_new;
                    n_k           = w_k_new;
                    n_step        = '0;
                    o_mem.smp_we  = 1'b1;
                    o_mem.wr_addr = w_pos_new;
                    o_mac.clear   = 1'b1;
                    n_state       = ST_RUN;
                end
            end
            ST_RUN: begin
                // even steps read the tap entry and take the feedforward
                // product, odd steps take the feedback product
                o_mem.rd_en   = !r_step[0];
                o_mem.rd_addr = w_j;
                o_mac.vld     = 1'b1;
                o_mac.fb      = r_step[0];
                o_mac.tap     = w_tap;
                n_step        = r_step + (POS_W+1)'(1);
                if (r_step == w_last_step) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_mac_busy) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (i_out_free) begin
                    o_mem.out_we  = 1'b1;
                    o_mem.wr_addr = r_pos;
                    o_fin         = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pos   <= '0;
            r_step  <= '0;
            r_k     <= (POS_W+1)'(1);
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_step  <= n_step;
            r_k     <= n_k;
        end
    end

endmodule

`default_nettype wire

[tb/sv/tb_direct_form_fir_iir_filter.sv]
`timescale 1ns / 1ps

module tb_direct_form_fir_iir_filter;

    import dffir_pkg::*;

    localparam int     HOLD_CYCLES  = 300;
    localparam int     DRAIN_CYCLES = 2 * MAX_TAPS + 8;
    localparam int     STALL_LIMIT  = 3000;
    localparam longint OUT_HI       = 64'sd2147483647;
    localparam longint OUT_LO       = -64'sd2147483648;

    typedef enum int {TAPS_GENTLE, TAPS_WIDE, TAPS_RAIL} t_taps_style;

    logic                  i_clk     = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [M_TDATA_W-1:0]  o_m_axis_tdata;
    logic                  o_cfg_ready;

    // filter state as the block should hold it
    logic [ORDER_W-1:0]      tap_order = ORDER_W'(1);
    logic                    iir_on    = 1'b0;
    logic [2*CFG_DATA_W-1:0] feed_taps = '0;
    logic [2*CFG_DATA_W-1:0] back_taps = '0;
    logic [SAMPLE_BITS-1:0]  smp_hist [MAX_TAPS] = '{default: '0};
    logic signed [OUT_W-1:0] out_hist [MAX_TAPS] = '{default: '0};
    logic [POS_W-1:0]        wr_pos    = '0;

    logic signed [OUT_W-1:0] filtered_q [$];
    logic signed [OUT_W-1:0] want_filtered;

    int send_idle_pct    = 9;
    int recv_idle_pct    = 62;
    int hold_requests    = 0;
    int hold_taken       = 0;
    int hold_left        = 0;
    int err_count        = 0;
    int samples_sent     = 0;
    int results_checked  = 0;
    int settings_applied = 0;
    int idle_run         = 0;

    direct_form_fir_iir_filter u_top (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (err_count < 40) begin
            $display("mismatch at %0t: %s, got %0d, expected %0d", $realtime, what, got, want);
        end
        err_count++;
    endtask

    function automatic longint tap_coef(input logic [2*CFG_DATA_W-1:0] set, input int i);
        logic signed [COEF_W-1:0] raw;
        raw = set[COEF_W*i +: COEF_W];
        return longint'(raw);
    endfunction

    // advances the circular histories and returns the saturated output
    function automatic logic signed [OUT_W-1:0] next_filtered(input logic [SAMPLE_BITS-1:0] smp);
        int     k;
        int     pos;
        int     j;
        longint acc;
        longint fb;
        k = (tap_order == '0) ? 1 : (tap_order > MAX_TAPS) ? MAX_TAPS : int'(tap_order);
        pos = int'(wr_pos) + 1;
        if (pos >= k) begin
            pos = 0;
        end
        wr_pos = POS_W'(pos);
        smp_hist[pos] = smp;
        acc = 0;
        for (int i = 0; i < k; i++) begin
            j = (pos + k - i) % k;
            acc += longint'(smp_hist[j]) * tap_coef(feed_taps, i);
            // feedback tap zero never takes part
            if (iir_on && i != 0) begin
                fb = longint'(out_hist[j]) * tap_coef(back_taps, i);
                acc -= fb >>> COEF_FRAC_BITS;
            end
        end
        if (acc > OUT_HI) begin
            acc = OUT_HI;
        end else if (acc < OUT_LO) begin
            acc = OUT_LO;
        end
        out_hist[pos] = OUT_W'(acc);
        return OUT_W'(acc);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] random_sample();
        int r;
        r = $urandom_range(99);
        if (r < 8) begin
            return '0;
        end else if (r < 16) begin
            return '1;
        end
        return SAMPLE_BITS'($urandom_range(2**SAMPLE_BITS - 1));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_taps(input t_taps_style style);
        logic [CFG_DATA_W-1:0] word;
        word = '0;
        for (int i = 0; i < CFG_DATA_W / COEF_W; i++) begin
            case (style)
                TAPS_GENTLE: begin
                    // within +-1/8, keeps feedback stable
                    word[COEF_W*i +: COEF_W] = COEF_W'($urandom_range(4095)) - COEF_W'(2048);
                end
                TAPS_WIDE: begin
                    word[COEF_W*i +: COEF_W] = COEF_W'($urandom());
                end
                default: begin
                    case ($urandom_range(3))
                        0: word[COEF_W*i +: COEF_W] = 16'h7FFF;
                        1: word[COEF_W*i +: COEF_W] = 16'h8000;
                        2: word[COEF_W*i +: COEF_W] = 16'hFFFF;
                        default: word[COEF_W*i +: COEF_W] = 16'h0001;
                    endcase
                end
            endcase
        end
        return word;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_ORDER:   tap_order = data[ORDER_W-1:0];
            CFG_MODE:    iir_on = data[0];
            CFG_FEED_LO: feed_taps[CFG_DATA_W-1:0] = data;
            CFG_FEED_HI: feed_taps[2*CFG_DATA_W-1:CFG_DATA_W] = data;
            CFG_BACK_LO: back_taps[CFG_DATA_W-1:0] = data;
            CFG_BACK_HI: back_taps[2*CFG_DATA_W-1:CFG_DATA_W] = data;
            default: ;
        endcase
    endtask

    // upper bits of the order and mode words are junk the block must ignore
    task automatic apply_settings(input logic [ORDER_W-1:0] ord, input logic mode,
                                  input logic [CFG_DATA_W-1:0] fl, input logic [CFG_DATA_W-1:0] fh,
                                  input logic [CFG_DATA_W-1:0] bl, input logic [CFG_DATA_W-1:0] bh);
        write_reg(CFG_ORDER, {$urandom(), 28'($urandom()), ord});
        write_reg(CFG_MODE, {$urandom(), 31'($urandom()), mode});
        write_reg(CFG_FEED_LO, fl);
        write_reg(CFG_FEED_HI, fh);
        write_reg(CFG_BACK_LO, bl);
        write_reg(CFG_BACK_HI, bh);
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    task automatic apply_random_settings(input logic [ORDER_W-1:0] ord);
        t_taps_style fs;
        t_taps_style bs;
        fs = t_taps_style'($urandom_range(2));
        bs = ($urandom_range(99) < 60) ? TAPS_GENTLE : t_taps_style'($urandom_range(2));
        apply_settings(ord, 1'($urandom_range(1)), random_taps(fs), random_taps(fs),
                       random_taps(bs), random_taps(bs));
    endtask

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp);
        int gap;
        gap = 0;
        if ($urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(1, 8);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(smp);
        do @(posedge i_clk); while (!o_s_axis_tready);
        filtered_q.push_back(next_filtered(smp));
        samples_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (filtered_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_reset_state();
        // order one, all coefficients zero
        send_sample('1);
        send_sample(10'h2AA);
        wait_idle();
    endtask

    task automatic test_feedforward_extremes();
        apply_settings(ORDER_W'(8), 1'b0, 64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF,
                       '0, '0);
        repeat (8) send_sample('1);
        send_sample(10'h155);
        send_sample(10'h2AA);
        wait_idle();
    endtask

    task automatic test_order_edges();
        apply_settings(ORDER_W'(0), 1'b0, 64'h1000_2000_3000_4000, 64'hF000_E000_C000_8000,
                       '0, '0);
        send_sample(10'd500);
        send_sample(10'd700);
        wait_idle();
        apply_settings(ORDER_W'(15), 1'b0, 64'h1000_2000_3000_4000, 64'hF000_E000_C000_8000,
                       '0, '0);
        send_sample(10'd3);
        send_sample(10'd1000);
        wait_idle();
        // shrinking then growing the order reuses stale history
        apply_settings(ORDER_W'(3), 1'b0, 64'h1000_2000_3000_4000, 64'hF000_E000_C000_8000,
                       '0, '0);
        send_sample(10'd77);
        wait_idle();
        apply_settings(ORDER_W'(5), 1'b0, 64'h1000_2000_3000_4000, 64'hF000_E000_C000_8000,
                       '0, '0);
        send_sample(10'd900);
        wait_idle();
    endtask

    task automatic test_feedback_saturation();
        // feedback of minus two per tap drives the output to the positive rail
        apply_settings(ORDER_W'(8), 1'b1, 64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF,
                       64'h8000_8000_8000_7FFF, 64'h8000_8000_8000_8000);
        repeat (5) send_sample('1);
        wait_idle();
        apply_settings(ORDER_W'(8), 1'b1, 64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF,
                       64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF);
        repeat (2) send_sample('0);
        wait_idle();
    endtask

    task automatic test_backpressure();
        apply_random_settings(ORDER_W'(8));
        send_idle_pct = 0;
        hold_requests++;
        repeat (40) send_sample(random_sample());
        wait_idle();
        send_idle_pct = 9;
    endtask

    task automatic test_random_phase(input int send_pct, input int recv_pct);
        logic [ORDER_W-1:0] ord;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int seg = 0; seg < 6; seg++) begin
            if ($urandom_range(99) < 20) begin
                ord = ORDER_W'($urandom_range(2**ORDER_W - 1));
            end else begin
                ord = ORDER_W'($urandom_range(1, MAX_TAPS));
            end
            apply_random_settings(ord);
            repeat ($urandom_range(60, 130)) send_sample(random_sample());
            wait_idle();
        end
    endtask

    // result side: checks each transaction and drives ready
    always @(posedge i_clk) begin
        if (m_tready && o_m_axis_tvalid) begin
            if (filtered_q.size() == 0) begin
                report_mismatch("result with nothing pending",
                                longint'($signed(o_m_axis_tdata[OUT_W-1:0])), 0);
            end else begin
                want_filtered = filtered_q.pop_front();
                if (o_m_axis_tdata[OUT_W-1:0] !== want_filtered) begin
                    report_mismatch("filtered", longint'($signed(o_m_axis_tdata[OUT_W-1:0])),
                                    longint'(want_filtered));
                end
                results_checked++;
            end
        end
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_taken != hold_requests) begin
            hold_taken <= hold_requests;
            hold_left  <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && o_s_axis_tready) || (m_tready && o_m_axis_tvalid)
                || (cfg_valid && o_cfg_ready)) begin
            idle_run = 0;
        end else begin
            idle_run++;
        end
        if (idle_run >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_feedforward_extremes();
        test_order_edges();
        test_feedback_saturation();
        test_backpressure();
        test_random_phase(9, 62);
        test_random_phase(62, 9);
        test_random_phase(0, 0);
        wait_idle();
        if (filtered_q.size() != 0) begin
            report_mismatch("results never delivered", filtered_q.size(), 0);
        end
        $display("covered %0d samples under %0d filter settings, fir and iir,",
                 samples_sent, settings_applied);
        $display("orders in and out of range; %0d filtered values checked, %0d mismatches",
                 results_checked, err_count);
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
